// ===== design/tus_pkg.sv =====
`timescale 1ns / 1ps
package tus_pkg;

    // reading kinds carried by the command field
    localparam logic [1:0] CMD_TEMP = 2'd0;
    localparam logic [1:0] CMD_VOLT = 2'd1;

    // register indexes on the configuration port
    localparam logic [1:0] REG_WARN_TEMP     = 2'd0;
    localparam logic [1:0] REG_CRIT_TEMP     = 2'd1;
    localparam logic [1:0] REG_MIN_BATT_MV   = 2'd2;
    localparam logic [1:0] REG_SHUTDOWN_DLY  = 2'd3;

    localparam int          APB_ADDR_W = 4;
    localparam int          APB_DATA_W = 32;

    // register reset values
    localparam logic [11:0] WARN_TEMP_RST    = 12'd800;
    localparam logic [11:0] CRIT_TEMP_RST    = 12'd1000;
    localparam logic [15:0] MIN_BATT_MV_RST  = 16'd18000;
    localparam logic [15:0] SHUTDOWN_DLY_RST = 16'd1500;

    // hottest value the running maximum can hold
    localparam logic [10:0] TEMP_MAX = 11'h7FF;

    // level codes as seen on the result
    localparam logic [1:0] LVL_CODE_NORMAL   = 2'd0;
    localparam logic [1:0] LVL_CODE_WARNING  = 2'd1;
    localparam logic [1:0] LVL_CODE_CRITICAL = 2'd2;
    localparam logic [1:0] LVL_CODE_SHUTDOWN = 2'd3;

    typedef enum logic [3:0] {
        LVL_NORMAL   = 4'b0001,
        LVL_WARNING  = 4'b0010,
        LVL_CRITICAL = 4'b0100,
        LVL_SHUTDOWN = 4'b1000
    } t_level;

    typedef struct packed {
        logic signed [11:0] warn_temperature;
        logic signed [11:0] critical_temperature;
        logic [15:0]        min_battery_mv;
        logic [15:0]        shutdown_delay_cycles;
    } t_cfg;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [16:0] reading_value;
        logic               end_of_cycle;
    } t_item;

    typedef struct packed {
        logic [1:0]  safety_level;
        logic        stop_motors;
        logic        fault_error;
        logic        over_temperature;
        logic        under_voltage;
        logic [10:0] peak_temperature;
        logic [15:0] lowest_voltage;
    } t_result;

    function automatic logic [1:0] level_code(input t_level lvl);
        logic [1:0] code;
        case (lvl)
            LVL_NORMAL:   code = LVL_CODE_NORMAL;
            LVL_WARNING:  code = LVL_CODE_WARNING;
            LVL_CRITICAL: code = LVL_CODE_CRITICAL;
            default:      code = LVL_CODE_SHUTDOWN;
        endcase
        return code;
    endfunction

endpackage

// ===== design/thermal_undervoltage_supervisor.sv =====
`timescale 1ns / 1ps
// thermal and undervoltage supervisor
//
// input channel (i_in_valid / o_in_ready): one reading per transaction, a
// temperature in 0.1 C (command 0), a voltage in mV (command 1) or nothing.
// a transaction with end_of_cycle set closes the control period: its own
// reading counts, the four-level supervisor steps, and one result goes out
// on the output channel (o_out_valid / i_out_ready). other transactions give
// no result. configuration sits on a 32-bit apb port, registers at 4*index.
//
// a closing transaction lands in the input register when accepted; its
// result loads into the result register once that is free. throughput: one
// transaction per cycle while no closing one waits; running extremes and
// supervisor update in a single pass of compare logic between the registers.
//
// reset clears the extremes, the supervisor (normal) and the critical period
// counter, and loads register defaults. when the receiver stalls, the result
// register holds; readings that close no period keep flowing, and a closing
// transaction waits in the input register until the result register frees.
module thermal_undervoltage_supervisor #(
    parameter int DELAY_COUNT_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // apb configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tus_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [tus_pkg::APB_DATA_W-1:0] pwdata,
    output logic [tus_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    // reading channel
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [1:0]                     i_command,
    input  logic signed [16:0]             i_reading_value,
    input  logic                           i_end_of_cycle,
    // result channel
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [1:0]                     o_safety_level,
    output logic                           o_stop_motors,
    output logic                           o_fault_error,
    output logic                           o_over_temperature,
    output logic                           o_under_voltage,
    output logic [10:0]                    o_peak_temperature,
    output logic [15:0]                    o_lowest_voltage
);

    tus_pkg::t_cfg    cfg;
    tus_pkg::t_item   r_item;
    tus_pkg::t_result eval_result;
    tus_pkg::t_result r_result;
    logic             r_in_valid;
    logic             r_out_valid;
    logic             advance;
    logic             in_fire;

    assign pready = 1'b1;

    tus_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (cfg)
    );

    // a held transaction moves on unless it closes a period while the
    // result register is still occupied
    assign advance    = r_in_valid && (!r_item.end_of_cycle || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign in_fire    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_item.command       <= i_command;
            r_item.reading_value <= i_reading_value;
            r_item.end_of_cycle  <= i_end_of_cycle;
        end
    end

    tus_period_eval #(
        .DELAY_COUNT_WIDTH (DELAY_COUNT_WIDTH)
    ) u_eval (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_item   (r_item),
        .i_fire   (advance),
        .o_result (eval_result)
    );

    // result register: loads on a period close, clears when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_item.end_of_cycle) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_item.end_of_cycle) begin
            r_result <= eval_result;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_safety_level     = r_result.safety_level;
    assign o_stop_motors      = r_result.stop_motors;
    assign o_fault_error      = r_result.fault_error;
    assign o_over_temperature = r_result.over_temperature;
    assign o_under_voltage    = r_result.under_voltage;
    assign o_peak_temperature = r_result.peak_temperature;
    assign o_lowest_voltage   = r_result.lowest_voltage;

endmodule

// ===== design/tus_cfg_regs.sv =====
`timescale 1ns / 1ps
module tus_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tus_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [tus_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [tus_pkg::APB_DATA_W-1:0]      prdata,
    output tus_pkg::t_cfg                       o_cfg
);

    tus_pkg::t_cfg r_cfg;
    logic [1:0]    reg_index;
    logic          wr_en;

    assign reg_index = paddr[3:2];
    assign wr_en     = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.warn_temperature      <= tus_pkg::WARN_TEMP_RST;
            r_cfg.critical_temperature  <= tus_pkg::CRIT_TEMP_RST;
            r_cfg.min_battery_mv        <= tus_pkg::MIN_BATT_MV_RST;
            r_cfg.shutdown_delay_cycles <= tus_pkg::SHUTDOWN_DLY_RST;
        end else if (wr_en) begin
            case (reg_index)
                tus_pkg::REG_WARN_TEMP:    r_cfg.warn_temperature      <= pwdata[11:0];
                tus_pkg::REG_CRIT_TEMP:    r_cfg.critical_temperature  <= pwdata[11:0];
                tus_pkg::REG_MIN_BATT_MV:  r_cfg.min_battery_mv        <= pwdata[15:0];
                tus_pkg::REG_SHUTDOWN_DLY: r_cfg.shutdown_delay_cycles <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_index)
            tus_pkg::REG_WARN_TEMP:    prdata = {20'd0, r_cfg.warn_temperature};
            tus_pkg::REG_CRIT_TEMP:    prdata = {20'd0, r_cfg.critical_temperature};
            tus_pkg::REG_MIN_BATT_MV:  prdata = {16'd0, r_cfg.min_battery_mv};
            tus_pkg::REG_SHUTDOWN_DLY: prdata = {16'd0, r_cfg.shutdown_delay_cycles};
            default:                   prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== design/tus_period_eval.sv =====
`timescale 1ns / 1ps
module tus_period_eval #(
    parameter int DELAY_COUNT_WIDTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tus_pkg::t_cfg    i_cfg,
    input  tus_pkg::t_item   i_item,
    input  logic             i_fire,
    output tus_pkg::t_result o_result
);

    localparam int CW = DELAY_COUNT_WIDTH;
    localparam int LW = (CW > 16) ? CW : 16;
    localparam logic [CW-1:0] COUNT_CAP = {CW{1'b1}};

    logic [10:0]             r_peak, n_peak;
    logic [15:0]             r_min_volt, n_min_volt;
    logic                    r_volt_seen, n_volt_seen;
    tus_pkg::t_level         r_level, n_level;
    logic [CW-1:0]           r_crit_count, n_crit_count;

    logic                    reading_pos;
    logic [10:0]             temp_clamped;
    logic [10:0]             peak_now;
    logic [15:0]             min_volt;
    logic                    volt_seen;
    logic [15:0]             low_volt;
    logic                    t_crit, t_warn, v_crit;
    logic [CW-1:0]           count_inc;
    logic [LW-1:0]           delay_ext, cap_ext, limit;

    // fold this transaction's reading into the running extremes
    always_comb begin
        reading_pos  = !i_item.reading_value[16] && (i_item.reading_value != '0);
        temp_clamped = (|i_item.reading_value[15:11]) ? tus_pkg::TEMP_MAX
                                                      : i_item.reading_value[10:0];
        peak_now  = r_peak;
        min_volt  = r_min_volt;
        volt_seen = r_volt_seen;
        if (i_item.command == tus_pkg::CMD_TEMP && reading_pos) begin
            if (temp_clamped > r_peak) begin
                peak_now = temp_clamped;
            end
        end else if (i_item.command == tus_pkg::CMD_VOLT && reading_pos) begin
            if (!r_volt_seen || i_item.reading_value[15:0] < r_min_volt) begin
                min_volt = i_item.reading_value[15:0];
            end
            volt_seen = 1'b1;
        end
        low_volt = volt_seen ? min_volt : 16'd0;
        t_crit   = $signed({2'b00, peak_now}) >
                   $signed({i_cfg.critical_temperature[11], i_cfg.critical_temperature});
        t_warn   = $signed({2'b00, peak_now}) >
                   $signed({i_cfg.warn_temperature[11], i_cfg.warn_temperature});
        v_crit   = volt_seen && (low_volt < i_cfg.min_battery_mv);
    end

    // supervisor step at period close
    always_comb begin
        delay_ext    = LW'(i_cfg.shutdown_delay_cycles);
        cap_ext      = LW'(COUNT_CAP);
        limit        = (delay_ext > cap_ext) ? cap_ext : delay_ext;
        count_inc    = (r_crit_count != COUNT_CAP) ? r_crit_count + 1'b1 : r_crit_count;
        n_level      = r_level;
        n_crit_count = r_crit_count;
        case (r_level)
            tus_pkg::LVL_NORMAL, tus_pkg::LVL_WARNING: begin
                if (t_crit || v_crit) begin
                    n_level      = tus_pkg::LVL_CRITICAL;
                    n_crit_count = '0;
                end else if (t_warn) begin
                    n_level = tus_pkg::LVL_WARNING;
                end else begin
                    n_level = tus_pkg::LVL_NORMAL;
                end
            end
            tus_pkg::LVL_CRITICAL: begin
                n_crit_count = count_inc;
                if (LW'(count_inc) >= limit) begin
                    n_level = tus_pkg::LVL_SHUTDOWN;
                end
            end
            default: begin
                n_level = tus_pkg::LVL_SHUTDOWN;
            end
        endcase
    end

    // period extremes restart after a close
    always_comb begin
        if (i_item.end_of_cycle) begin
            n_peak      = '0;
            n_min_volt  = '1;
            n_volt_seen = 1'b0;
        end else begin
            n_peak      = peak_now;
            n_min_volt  = min_volt;
            n_volt_seen = volt_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak       <= '0;
            r_min_volt   <= '1;
            r_volt_seen  <= 1'b0;
            r_level      <= tus_pkg::LVL_NORMAL;
            r_crit_count <= '0;
        end else if (i_fire) begin
            r_peak      <= n_peak;
            r_min_volt  <= n_min_volt;
            r_volt_seen <= n_volt_seen;
            if (i_item.end_of_cycle) begin
                r_level      <= n_level;
                r_crit_count <= n_crit_count;
            end
        end
    end

    always_comb begin
        o_result.safety_level     = tus_pkg::level_code(n_level);
        o_result.stop_motors      = (n_level == tus_pkg::LVL_CRITICAL) ||
                                    (n_level == tus_pkg::LVL_SHUTDOWN);
        o_result.fault_error      = (n_level == tus_pkg::LVL_SHUTDOWN);
        o_result.over_temperature = t_crit;
        o_result.under_voltage    = v_crit;
        o_result.peak_temperature = peak_now;
        o_result.lowest_voltage   = low_volt;
    end

endmodule

// ===== design/tus_checker.sv =====
`timescale 1ns / 1ps
module tus_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_safety_level,
    input logic        o_stop_motors,
    input logic        o_fault_error,
    input logic        o_under_voltage,
    input logic [10:0] o_peak_temperature,
    input logic [15:0] o_lowest_voltage
);

    // a stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_safety_level) &&
        $stable(o_peak_temperature) && $stable(o_lowest_voltage))
        else $error("result changed while stalled");

    // stop request follows the level
    a_stop_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_stop_motors == (o_safety_level == tus_pkg::LVL_CODE_CRITICAL ||
                                          o_safety_level == tus_pkg::LVL_CODE_SHUTDOWN))
        else $error("stop_motors disagrees with level");

    // fault only in shutdown
    a_fault_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_fault_error == (o_safety_level == tus_pkg::LVL_CODE_SHUTDOWN))
        else $error("fault_error disagrees with level");

    // undervoltage needs a seen voltage
    a_uv_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_under_voltage |-> o_lowest_voltage != 16'd0)
        else $error("undervoltage without a voltage reading");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind thermal_undervoltage_supervisor tus_checker u_tus_checker (.*);
